/* sv/i2ci_pkg.sv */
// ----------------------------------------------------------------------------
// i2ci_pkg
// Shared types, opcodes and constants of the bus command interpreter.
// ----------------------------------------------------------------------------
package i2ci_pkg;

  localparam int BUFFER_DEPTH = 32;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_FILL_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] HEADER     = 8'hCA;
  localparam logic [7:0] OP_MODE    = 8'h60;
  localparam logic [7:0] OP_PERIOD  = 8'h61;
  localparam logic [7:0] OP_GAIN    = 8'h62;
  localparam logic [7:0] OP_MUX     = 8'h63;
  localparam logic [7:0] OP_SYNC    = 8'h64;
  localparam logic [7:0] OP_PDOWN   = 8'h65;
  localparam logic [7:0] OP_PUP     = 8'h66;
  localparam logic [7:0] OP_REQ     = 8'h6F;
  localparam logic [7:0] OP_BEGIN   = 8'h9A;
  localparam logic [7:0] OP_MEMTEST = 8'h9B;

  localparam logic [3:0] ADDR_NIB   = 4'h5;
  localparam logic [3:0] PWR_NIB    = 4'hE;
  localparam logic [7:0] PWR_XOR    = 8'h0F;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } back_state_t;

  typedef enum logic [1:0] {
    PH_HDR,
    PH_OP,
    PH_ARG
  } parse_phase_t;

  typedef struct packed {
    logic       is_end;
    logic       addr_cand;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [6:0] own_address;
    logic       address_set;
    logic [7:0] mode;
    logic [7:0] period;
    logic [7:0] gain;
    logic [4:0] pga_code;
    logic       test_mode;
    logic [7:0] channel_mask;
    logic       sync_flag;
    logic       request_flag;
    logic       start_pulse;
    logic       overflow;
  } result_t;

  function automatic logic [4:0] gain_to_pga(input logic [7:0] g);
    logic [4:0] code;
    case (g)
      8'd1:    code = 5'h03;
      8'd2:    code = 5'h05;
      8'd3:    code = 5'h07;
      8'd4:    code = 5'h09;
      8'd5:    code = 5'h0B;
      8'd6:    code = 5'h0C;
      8'd7:    code = 5'h0F;
      8'd8:    code = 5'h11;
      default: code = 5'h01;
    endcase
    return code;
  endfunction

endpackage

/* sv/i2ci_ram.sv */
// ----------------------------------------------------------------------------
// i2ci_ram
// Generic RAM, one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module i2ci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/i2ci_front.sv */
// ----------------------------------------------------------------------------
// i2ci_front
// Accepts input beats, tags end-of-message and address candidates, and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module i2ci_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          action,
  input  logic [7:0]    data_byte,
  output logic          cmd_valid,
  output i2ci_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  localparam int PW = i2ci_pkg::Q_PTR_W;
  localparam int FW = i2ci_pkg::Q_FILL_W;

  i2ci_pkg::cmd_t slot [i2ci_pkg::Q_DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [FW-1:0]  fill;
  logic           push;
  i2ci_pkg::cmd_t cmd_in;

  assign in_ready  = (fill != FW'(i2ci_pkg::Q_DEPTH));
  assign cmd_valid = (fill != '0);
  assign push      = in_valid && in_ready;
  assign cmd       = slot[rptr];

  always_comb begin
    cmd_in.is_end    = action;
    cmd_in.addr_cand = (data_byte[7:4] == i2ci_pkg::ADDR_NIB);
    cmd_in.data      = data_byte;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(i2ci_pkg::Q_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (cmd_pop) begin
        rptr <= (rptr == PW'(i2ci_pkg::Q_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      case ({push, cmd_pop})
        2'b10:   fill <= fill + FW'(1);
        2'b01:   fill <= fill - FW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* sv/i2ci_back.sv */
// ----------------------------------------------------------------------------
// i2ci_back
// Executes queued beats: stores bytes or the address, walks the message
// buffer at end of message, and holds the result beat for the output.
// ----------------------------------------------------------------------------
module i2ci_back #(
  parameter int BUFFER_DEPTH = i2ci_pkg::BUFFER_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  i2ci_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output i2ci_pkg::result_t res
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  i2ci_pkg::back_state_t  state;
  i2ci_pkg::back_state_t  state_next;
  i2ci_pkg::parse_phase_t phase;

  logic [CW-1:0] count;
  logic [AW-1:0] proc;
  logic [7:0]    pend_op;
  logic          pulse;
  logic          ovf;

  logic [6:0] addr_store;
  logic       addr_set;
  logic [7:0] mode_store;
  logic [7:0] period_store;
  logic [7:0] gain_store;
  logic [4:0] pga_store;
  logic       test_store;
  logic [7:0] mask_store;
  logic       sync_store;
  logic       req_store;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    rd_data;
  logic          load_out;
  logic          take_addr;
  logic          has_room;
  logic          last;
  logic          walk_done;

  assign take_addr = !addr_set && cmd.addr_cand;
  assign has_room  = (count < CW'(BUFFER_DEPTH));
  assign last      = ((CW'(proc) + CW'(1)) == count);
  assign walk_done = last || ((phase == i2ci_pkg::PH_HDR) && (rd_data != i2ci_pkg::HEADER));

  i2ci_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[AW-1:0]),
    .wdata(cmd.data),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      i2ci_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.is_end && (count != '0)) begin
            state_next = i2ci_pkg::ST_WALK;
          end else begin
            state_next = i2ci_pkg::ST_EMIT;
          end
        end
      end
      i2ci_pkg::ST_WALK: begin
        if (walk_done) begin
          state_next = i2ci_pkg::ST_EMIT;
        end
      end
      i2ci_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = i2ci_pkg::ST_IDLE;
        end
      end
      default: state_next = i2ci_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = '0;
    load_out  = 1'b0;
    case (state)
      i2ci_pkg::ST_IDLE: begin
        cmd_pop = cmd_valid;
        ram_we  = cmd_valid && !cmd.is_end && !take_addr && has_room;
      end
      i2ci_pkg::ST_WALK: begin
        ram_raddr = proc + AW'(1);
      end
      i2ci_pkg::ST_EMIT: begin
        load_out = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2ci_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= i2ci_pkg::PH_HDR;
      count        <= '0;
      proc         <= '0;
      pend_op      <= '0;
      pulse        <= 1'b0;
      ovf          <= 1'b0;
      addr_store   <= '0;
      addr_set     <= 1'b0;
      mode_store   <= '0;
      period_store <= '0;
      gain_store   <= '0;
      pga_store    <= '0;
      test_store   <= 1'b0;
      mask_store   <= '0;
      sync_store   <= 1'b0;
      req_store    <= 1'b0;
    end else begin
      if (cmd_pop) begin
        pulse <= 1'b0;
        ovf   <= 1'b0;
        phase <= i2ci_pkg::PH_HDR;
        proc  <= '0;
        if (!cmd.is_end) begin
          if (take_addr) begin
            addr_store <= cmd.data[6:0];
            addr_set   <= 1'b1;
          end else if (has_room) begin
            count <= count + CW'(1);
          end else begin
            ovf <= 1'b1;
          end
        end
      end
      if (state == i2ci_pkg::ST_WALK) begin
        proc <= proc + AW'(1);
        if (walk_done) begin
          count <= '0;
        end
        case (phase)
          i2ci_pkg::PH_HDR: begin
            if (rd_data == i2ci_pkg::HEADER) begin
              phase <= i2ci_pkg::PH_OP;
            end
          end
          i2ci_pkg::PH_OP: begin
            if (rd_data == i2ci_pkg::OP_BEGIN) begin
              pulse <= 1'b1;
            end else if (rd_data != i2ci_pkg::OP_MEMTEST) begin
              pend_op <= rd_data;
              phase   <= i2ci_pkg::PH_ARG;
            end
          end
          i2ci_pkg::PH_ARG: begin
            phase <= i2ci_pkg::PH_OP;
            case (pend_op)
              i2ci_pkg::OP_MODE:   mode_store <= rd_data;
              i2ci_pkg::OP_PERIOD: period_store <= rd_data;
              i2ci_pkg::OP_GAIN: begin
                gain_store <= rd_data;
                pga_store  <= i2ci_pkg::gain_to_pga(rd_data);
              end
              i2ci_pkg::OP_MUX:    test_store <= (rd_data == 8'h00);
              i2ci_pkg::OP_SYNC:   sync_store <= 1'b1;
              i2ci_pkg::OP_PDOWN: begin
                if (rd_data[7:4] == i2ci_pkg::PWR_NIB) begin
                  mask_store <= mask_store & (rd_data ^ i2ci_pkg::PWR_XOR);
                end
              end
              i2ci_pkg::OP_PUP: begin
                if (rd_data[7:4] == i2ci_pkg::PWR_NIB) begin
                  mask_store <= mask_store | rd_data;
                end
              end
              i2ci_pkg::OP_REQ:    req_store <= 1'b1;
              default: ;
            endcase
          end
          default: phase <= i2ci_pkg::PH_HDR;
        endcase
      end
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      res       <= '0;
    end else begin
      if (load_out) begin
        out_valid        <= 1'b1;
        res.own_address  <= addr_store;
        res.address_set  <= addr_set;
        res.mode         <= mode_store;
        res.period       <= period_store;
        res.gain         <= gain_store;
        res.pga_code     <= pga_store;
        res.test_mode    <= test_store;
        res.channel_mask <= mask_store;
        res.sync_flag    <= sync_store;
        res.request_flag <= req_store;
        res.start_pulse  <= pulse;
        res.overflow     <= ovf;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/i2c_command_interpreter_top.sv */
// Flow: a byte beat passes through the front queue, the back end's idle state
// and its emit state before its result beat is registered; an end-of-message
// beat also walks the buffer RAM, one entry per cycle, ending early on a bad header.
// The back end takes no new beat until its emit state has loaded the result beat, which waits on a stalled output.
// Reset (rst, synchronous): clears settings, address, byte count and queue;
// buffer RAM contents are left as they are and never used before written.
// ----------------------------------------------------------------------------
// i2c_command_interpreter_top
// Bus command interpreter: queued front end, buffer-walking back end.
// ----------------------------------------------------------------------------
module i2c_command_interpreter_top #(
  parameter int BUFFER_DEPTH = i2ci_pkg::BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] own_address,
  output logic       address_set,
  output logic [7:0] mode,
  output logic [7:0] period,
  output logic [7:0] gain,
  output logic [4:0] pga_code,
  output logic       test_mode,
  output logic [7:0] channel_mask,
  output logic       sync_flag,
  output logic       request_flag,
  output logic       start_pulse,
  output logic       overflow
);

  logic              cmd_valid;
  logic              cmd_pop;
  i2ci_pkg::cmd_t    cmd;
  i2ci_pkg::result_t res;

  i2ci_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .data_byte(data_byte),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  i2ci_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res      (res)
  );

  assign own_address  = res.own_address;
  assign address_set  = res.address_set;
  assign mode         = res.mode;
  assign period       = res.period;
  assign gain         = res.gain;
  assign pga_code     = res.pga_code;
  assign test_mode    = res.test_mode;
  assign channel_mask = res.channel_mask;
  assign sync_flag    = res.sync_flag;
  assign request_flag = res.request_flag;
  assign start_pulse  = res.start_pulse;
  assign overflow     = res.overflow;

endmodule

/* sv/i2ci_checker.sv */
// ----------------------------------------------------------------------------
// i2ci_checker
// Port-level checks of the command interpreter, bound to the top level.
// ----------------------------------------------------------------------------
module i2ci_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] own_address,
  input logic       address_set,
  input logic [7:0] mode,
  input logic [7:0] period,
  input logic [7:0] gain,
  input logic [4:0] pga_code,
  input logic       test_mode,
  input logic [7:0] channel_mask,
  input logic       sync_flag,
  input logic       request_flag,
  input logic       start_pulse,
  input logic       overflow
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(own_address) && $stable(address_set)
      && $stable(mode) && $stable(period) && $stable(gain) && $stable(pga_code)
      && $stable(test_mode) && $stable(channel_mask) && $stable(sync_flag)
      && $stable(request_flag) && $stable(start_pulse) && $stable(overflow))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_pulse_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(start_pulse && overflow))
    else $error("start pulse and overflow in one beat");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && ($past(address_set) || $past(sync_flag) || $past(request_flag)) |->
      (address_set || !$past(address_set)) && (sync_flag || !$past(sync_flag))
      && (request_flag || !$past(request_flag)))
    else $error("sticky flag cleared");

  a_pga_gain: assert property (@(posedge clk) disable iff (rst)
    out_valid && (pga_code == 5'd0) |-> (gain == 8'd0))
    else $error("zero amplifier code with gain set");

endmodule

bind i2c_command_interpreter_top i2ci_checker u_chk (.*);
